// File: rtl/sca_pkg.sv
package sca_pkg;

    // field widths of the request and result ports
    localparam int CMD_W      = 1;
    localparam int SIZE_W     = 11;
    localparam int CLASS_W    = 4;
    localparam int SLOT_W_IO  = 11;
    localparam int STATUS_W   = 3;

    // default geometry
    localparam int PAGE_BYTES_DEF  = 4096;
    localparam int NUM_CLASSES_DEF = 10;
    localparam int SMALL_LIMIT_DEF = 1024;

    // bitmap word of the in-use memory
    localparam int WORD_BITS = 64;
    localparam int BIT_W     = 6;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BIG      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

endpackage

// File: rtl/size_class_slot_allocator_top.sv
// power-of-two size-class slot allocator
//
// request channel (i_valid / o_ready): i_cmd selects allocate or free. an
// allocate rounds i_req_size up to a power of two (minimum 2 bytes) and
// claims the lowest free slot of that class; a free clears the in-use bit
// named by i_free_class / i_free_slot. result channel (o_valid / i_ready):
// one result per request, o_status plus the granted class and slot.
//
// the in-use bits sit in one synchronous memory, one 64-bit word per row,
// each class owning a fixed run of rows. an allocate reads the class rows
// in order, one row per cycle, until a free bit turns up, scanning up to
// 32 rows with the default page. a free is a read-modify-write of one row.
// requests that fail the size or range checks skip the memory. one request
// is worked at a time.
//
// after reset the block sweeps every memory row to zero, one row per cycle
// (NUM_CLASSES * 2^(clog2(PAGE_BYTES/2)-6) rows, 320 with defaults) and
// holds o_ready low until done. a finished result waits in an output
// register, so the next request is taken while the receiver stalls; that
// request then holds in its final state until the output register frees.
module size_class_slot_allocator_top #(
    parameter int PAGE_BYTES  = sca_pkg::PAGE_BYTES_DEF,
    parameter int NUM_CLASSES = sca_pkg::NUM_CLASSES_DEF,
    parameter int SMALL_LIMIT = sca_pkg::SMALL_LIMIT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [sca_pkg::CMD_W-1:0]      i_cmd,
    input  logic [sca_pkg::SIZE_W-1:0]     i_req_size,
    input  logic [sca_pkg::CLASS_W-1:0]    i_free_class,
    input  logic [sca_pkg::SLOT_W_IO-1:0]  i_free_slot,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [sca_pkg::STATUS_W-1:0]   o_status,
    output logic [sca_pkg::CLASS_W-1:0]    o_alloc_class,
    output logic [sca_pkg::SLOT_W_IO-1:0]  o_alloc_slot
);
    import sca_pkg::*;

    // geometry derived from the page
    localparam int MAX_SLOTS = PAGE_BYTES / 2;
    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int WORD_W    = SLOT_W - BIT_W;
    localparam int CIDX_W    = $clog2(NUM_CLASSES);
    localparam int ADDR_W    = CIDX_W + WORD_W;
    localparam int DEPTH     = NUM_CLASSES << WORD_W;
    localparam int N_W       = $clog2(PAGE_BYTES) + 1;
    localparam int LIM_W     = $clog2(SMALL_LIMIT + 1);

    // controller states
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ARD   = 3'd2;
    localparam logic [2:0] S_ACHK  = 3'd3;
    localparam logic [2:0] S_FRD   = 3'd4;
    localparam logic [2:0] S_FWR   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    // index of the top set bit, zero for zero
    function automatic logic [CLASS_W-1:0] top_bit(input logic [SIZE_W-1:0] v);
        logic [CLASS_W-1:0] r;
        r = '0;
        for (int i = 0; i < SIZE_W; i++) begin
            if (v[i]) begin
                r = CLASS_W'(i);
            end
        end
        return r;
    endfunction

    logic [WORD_BITS-1:0] r_mem [0:DEPTH-1];
    logic [WORD_BITS-1:0] r_rdata;

    logic [2:0]           r_state, n_state;
    logic [ADDR_W-1:0]    r_addr, n_addr;
    logic [CLASS_W-1:0]   r_cls, n_cls;
    logic [SLOT_W-1:0]    r_slot, n_slot;
    logic [N_W-1:0]       r_nslots, n_nslots;
    logic [WORD_W-1:0]    r_word, n_word;

    logic [STATUS_W-1:0]  r_res_status, n_res_status;
    logic [CLASS_W-1:0]   r_res_class, n_res_class;
    logic [SLOT_W_IO-1:0] r_res_slot, n_res_slot;

    logic                 r_out_valid, n_out_valid;
    logic [STATUS_W-1:0]  r_out_status, n_out_status;
    logic [CLASS_W-1:0]   r_out_class, n_out_class;
    logic [SLOT_W_IO-1:0] r_out_slot, n_out_slot;

    // memory port controls
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic [ADDR_W-1:0]    rd_addr;

    // request decode
    logic [SIZE_W-1:0]          size_m1;
    logic [CLASS_W-1:0]         req_cls;
    logic [CLASS_W-1:0]         sel_cls;
    logic [N_W-1:0]             sel_n;
    logic                       too_big;
    logic                       free_bad;
    logic [N_W+SLOT_W_IO-1:0]   fslot_cmp;
    logic [N_W+SLOT_W_IO-1:0]   n_cmp;
    logic [SLOT_W+SLOT_W_IO-1:0] fslot_ext;

    // word search
    logic [N_W-1:0]             rem;
    logic [WORD_BITS-1:0]       valid_mask;
    logic [WORD_BITS-1:0]       free_bits;
    logic                       found;
    logic [BIT_W-1:0]           hit_idx;
    logic                       last_word;
    logic [SLOT_W-1:0]          hit_slot;
    logic [SLOT_W+SLOT_W_IO-1:0] hit_ext;

    assign size_m1   = i_req_size - SIZE_W'(1);
    assign req_cls   = top_bit(size_m1);
    assign sel_cls   = (i_cmd == CMD_FREE) ? i_free_class : req_cls;
    assign sel_n     = N_W'(PAGE_BYTES) >> ({1'b0, sel_cls} + 5'd1);
    assign too_big   = ({{SIZE_W{1'b0}}, {LIM_W{1'b0}}} | (LIM_W + SIZE_W)'(i_req_size))
                       > (LIM_W + SIZE_W)'(SMALL_LIMIT);
    assign fslot_cmp = (N_W + SLOT_W_IO)'(i_free_slot);
    assign n_cmp     = (N_W + SLOT_W_IO)'(sel_n);
    assign free_bad  = (32'(i_free_class) >= 32'(NUM_CLASSES)) || (fslot_cmp >= n_cmp);
    assign fslot_ext = {{SLOT_W{1'b0}}, i_free_slot};

    // slots of this class that fall in the current row
    assign rem        = r_nslots - N_W'({r_word, {BIT_W{1'b0}}});
    assign valid_mask = (rem >= N_W'(WORD_BITS)) ? '1
                        : ((WORD_BITS'(1) << rem[BIT_W-1:0]) - WORD_BITS'(1));
    assign free_bits  = ~r_rdata & valid_mask;
    assign found      = |free_bits;
    assign last_word  = rem <= N_W'(WORD_BITS);
    assign hit_slot   = {r_word, hit_idx};
    assign hit_ext    = {{SLOT_W_IO{1'b0}}, hit_slot};

    // lowest free bit of the row
    always_comb begin
        hit_idx = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (free_bits[j]) begin
                hit_idx = BIT_W'(j);
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_cls        = r_cls;
        n_slot       = r_slot;
        n_nslots     = r_nslots;
        n_word       = r_word;
        n_res_status = r_res_status;
        n_res_class  = r_res_class;
        n_res_slot   = r_res_slot;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_class  = r_out_class;
        n_out_slot   = r_out_slot;
        wr_en        = 1'b0;
        wr_addr      = r_addr;
        wr_data      = '0;
        rd_addr      = {r_cls[CIDX_W-1:0], r_word};

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                // zero sweep after reset
                wr_en  = 1'b1;
                n_addr = r_addr + ADDR_W'(1);
                if (r_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_res_class = '0;
                    n_res_slot  = '0;
                    n_cls       = sel_cls;
                    n_nslots    = sel_n;
                    n_word      = '0;
                    n_slot      = fslot_ext[SLOT_W-1:0];
                    if (i_cmd == CMD_FREE) begin
                        if (free_bad) begin
                            n_res_status = ST_NOTFOUND;
                            n_state      = S_DONE;
                        end else begin
                            n_state = S_FRD;
                        end
                    end else begin
                        priority if (i_req_size == '0) begin
                            n_res_status = ST_ZERO;
                            n_state      = S_DONE;
                        end else if (too_big || 32'(req_cls) >= 32'(NUM_CLASSES)) begin
                            n_res_status = ST_BIG;
                            n_state      = S_DONE;
                        end else if (sel_n == '0) begin
                            n_res_status = ST_FULL;
                            n_state      = S_DONE;
                        end else begin
                            n_state = S_ARD;
                        end
                    end
                end
            end
            S_ARD: begin
                n_state = S_ACHK;
            end
            S_ACHK: begin
                // look ahead at the next row while this one is checked
                rd_addr = {r_cls[CIDX_W-1:0], r_word + WORD_W'(1)};
                priority if (found) begin
                    wr_en        = 1'b1;
                    wr_addr      = {r_cls[CIDX_W-1:0], r_word};
                    wr_data      = r_rdata | (WORD_BITS'(1) << hit_idx);
                    n_res_status = ST_OK;
                    n_res_class  = r_cls;
                    n_res_slot   = hit_ext[SLOT_W_IO-1:0];
                    n_state      = S_DONE;
                end else if (last_word) begin
                    n_res_status = ST_FULL;
                    n_state      = S_DONE;
                end else begin
                    n_word = r_word + WORD_W'(1);
                end
            end
            S_FRD: begin
                rd_addr = {r_cls[CIDX_W-1:0], r_slot[SLOT_W-1:BIT_W]};
                n_state = S_FWR;
            end
            S_FWR: begin
                wr_en        = 1'b1;
                wr_addr      = {r_cls[CIDX_W-1:0], r_slot[SLOT_W-1:BIT_W]};
                wr_data      = r_rdata & ~(WORD_BITS'(1) << r_slot[BIT_W-1:0]);
                n_res_status = ST_OK;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_class  = r_res_class;
                    n_out_slot   = r_res_slot;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // in-use memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cls        <= n_cls;
        r_slot       <= n_slot;
        r_nslots     <= n_nslots;
        r_word       <= n_word;
        r_res_status <= n_res_status;
        r_res_class  <= n_res_class;
        r_res_slot   <= n_res_slot;
        r_out_status <= n_out_status;
        r_out_class  <= n_out_class;
        r_out_slot   <= n_out_slot;
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_alloc_class = r_out_class;
    assign o_alloc_slot  = r_out_slot;

    // no request taken while the sweep runs
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_ready)
        else $error("request accepted during clearing sweep");

    // failed results carry no grant
    a_fail_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_alloc_class == '0 && o_alloc_slot == '0))
        else $error("grant fields set on a failed result");

    // a granted class is a real class
    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(o_alloc_class) < 32'(NUM_CLASSES)))
        else $error("granted class out of range");

    // memory written only by the sweep, a grant or a free
    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_state == S_CLEAR || r_state == S_ACHK || r_state == S_FWR))
        else $error("memory written outside an update state");

    // a grant ends the search
    a_grant_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACHK && wr_en) |=> (r_state == S_DONE && r_res_status == ST_OK))
        else $error("search went on after a grant");

endmodule
